[rtl/hbc_pkg.sv]
// ----------------------------------------------------------------------------
// hbc_pkg
// Shared types and constants of the hashed block cache directory.
// ----------------------------------------------------------------------------
`default_nettype none

package hbc_pkg;

    localparam int NUM_BUFFERS_DEF = 32;
    localparam int NUM_BUCKETS_DEF = 13;
    localparam int IDX_W           = 6;    // covers the largest buffer count
    localparam int BKT_W           = 4;
    localparam int MASK_W          = 16;   // one bit per possible bucket
    localparam int REFS_W          = 6;
    localparam logic [REFS_W-1:0] REFS_MAX = '1;

    typedef enum logic [2:0] {
        ST_HIT      = 3'd0,
        ST_REUSE    = 3'd1,
        ST_STEAL    = 3'd2,
        ST_NONE     = 3'd3,
        ST_RELEASED = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        UPD_INC   = 2'd0,
        UPD_CLAIM = 2'd1,
        UPD_REL   = 2'd2
    } upd_kind_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MOD,
        S_PASS1_GO,
        S_PASS1_WAIT,
        S_PASS2_GO,
        S_PASS2_WAIT,
        S_DONE
    } state_t;

    // search word that travels down the row of cells
    typedef struct packed {
        logic              valid;
        logic [15:0]       dev;
        logic [31:0]       blk;
        logic [BKT_W-1:0]  bucket;
        logic              match_v;
        logic [IDX_W-1:0]  match_idx;
        logic              free_v;
        logic [31:0]       free_tick;
        logic [IDX_W-1:0]  free_idx;
        logic [MASK_W-1:0] free_mask;
    } pkt_t;

    // update broadcast to all cells
    typedef struct packed {
        logic             valid;
        upd_kind_t        kind;
        logic [IDX_W-1:0] idx;
        logic [15:0]      dev;
        logic [31:0]      blk;
        logic [BKT_W-1:0] home;
        logic [31:0]      tick;
    } upd_t;

endpackage

`default_nettype wire

[rtl/hbc_cell.sv]
// ----------------------------------------------------------------------------
// hbc_cell
// One buffer entry: holds its state, merges it into the passing search word.
// ----------------------------------------------------------------------------
`default_nettype none

module hbc_cell #(
    parameter int IDX         = 0,
    parameter int NUM_BUCKETS = hbc_pkg::NUM_BUCKETS_DEF
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire hbc_pkg::pkt_t pkt_in,
    input  wire hbc_pkg::upd_t upd,
    output hbc_pkg::pkt_t      pkt_out
);

    localparam logic [hbc_pkg::IDX_W-1:0] MY_IDX = hbc_pkg::IDX_W'(IDX);

    logic [15:0]                dev_reg;
    logic [31:0]                blk_reg;
    logic [hbc_pkg::REFS_W-1:0] refs_reg;
    logic [31:0]                last_reg;
    logic [hbc_pkg::BKT_W-1:0]  bkt_reg;
    hbc_pkg::pkt_t              pkt_next;
    hbc_pkg::pkt_t              pkt_reg;
    logic                       is_free;

    // merge this entry into the search word
    always_comb
    begin
        pkt_next = pkt_in;
        is_free  = (refs_reg == '0);
        if (!pkt_in.match_v && bkt_reg == pkt_in.bucket && dev_reg == pkt_in.dev &&
            blk_reg == pkt_in.blk)
        begin
            pkt_next.match_v   = 1'b1;
            pkt_next.match_idx = MY_IDX;
        end
        if (is_free && bkt_reg == pkt_in.bucket &&
            (!pkt_in.free_v || last_reg < pkt_in.free_tick))
        begin
            pkt_next.free_v    = 1'b1;
            pkt_next.free_tick = last_reg;
            pkt_next.free_idx  = MY_IDX;
        end
        if (is_free)
        begin
            pkt_next.free_mask = pkt_in.free_mask |
                                 (hbc_pkg::MASK_W'(1) << bkt_reg);
        end
    end

    // hand the word to the neighbor
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pkt_reg <= '0;
        end
        else
        begin
            pkt_reg <= pkt_next;
        end
    end

    assign pkt_out = pkt_reg;

    // apply updates addressed to this entry
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dev_reg  <= '0;
            blk_reg  <= '0;
            refs_reg <= '0;
            last_reg <= '0;
            bkt_reg  <= hbc_pkg::BKT_W'(IDX % NUM_BUCKETS);
        end
        else if (upd.valid && upd.idx == MY_IDX)
        begin
            case (upd.kind)
                hbc_pkg::UPD_INC:
                begin
                    if (refs_reg != hbc_pkg::REFS_MAX)
                    begin
                        refs_reg <= refs_reg + 1'b1;
                    end
                end
                hbc_pkg::UPD_CLAIM:
                begin
                    dev_reg  <= upd.dev;
                    blk_reg  <= upd.blk;
                    refs_reg <= hbc_pkg::REFS_W'(1);
                    bkt_reg  <= upd.home;
                end
                hbc_pkg::UPD_REL:
                begin
                    if (refs_reg != '0)
                    begin
                        refs_reg <= refs_reg - 1'b1;
                        if (refs_reg == hbc_pkg::REFS_W'(1))
                        begin
                            last_reg <= upd.tick;
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

endmodule

`default_nettype wire

[rtl/hashed_block_cache_lru_lookup_top.sv]
// ----------------------------------------------------------------------------
// hashed_block_cache_lru_lookup_top
// Block cache directory with hashed buckets and oldest-free replacement.
// ----------------------------------------------------------------------------
// One word at a time. A release goes from acceptance straight to the result. A
// get first reduces the block number modulo the bucket count by a byte fold, a
// reciprocal multiply and a subtract, then sends a search word down the row of
// NUM_BUFFERS cells; when the home bucket has neither a match nor a free buffer
// a second pass finds the oldest free buffer of the chosen bucket. A waiting
// result holds the next word off.
`default_nettype none

module hashed_block_cache_lru_lookup_top #(
    parameter int NUM_BUFFERS = hbc_pkg::NUM_BUFFERS_DEF,
    parameter int NUM_BUCKETS = hbc_pkg::NUM_BUCKETS_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic        opcode,
    input  wire logic [15:0] device_id,
    input  wire logic [31:0] block_number,
    input  wire logic [4:0]  release_index,
    input  wire logic [31:0] now_tick,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [4:0]       buffer_index,
    output logic [2:0]       status
);

    localparam int IW     = hbc_pkg::IDX_W;
    localparam int BW     = hbc_pkg::BKT_W;
    localparam int FOLD_W = 14;
    localparam int C1     = 256 % NUM_BUCKETS;
    localparam int C2     = 65536 % NUM_BUCKETS;
    localparam int C3     = (1 << 24) % NUM_BUCKETS;
    localparam int REC_S  = 18;
    localparam int REC_M  = ((1 << REC_S) + NUM_BUCKETS - 1) / NUM_BUCKETS;

    hbc_pkg::state_t    state_reg, state_next;
    logic               op_reg;
    logic [15:0]        dev_reg;
    logic [31:0]        blk_reg;
    logic [IW-1:0]      rel_reg;
    logic [31:0]        tick_reg;
    logic [BW-1:0]      home_reg;
    logic [BW-1:0]      target_reg;
    logic [1:0]         cnt_reg;
    logic [FOLD_W-1:0]  fold_reg, fold_next;
    logic [FOLD_W-1:0]  quot_reg, quot_next;
    logic [31:0]        rec_prod;
    logic [FOLD_W-1:0]  rem_full;
    logic [IW-1:0]      res_idx_reg, res_idx_next;
    hbc_pkg::status_t   res_st_reg, res_st_next;
    hbc_pkg::upd_kind_t res_kind_reg, res_kind_next;
    logic               res_upd_reg, res_upd_next;
    logic               out_valid_reg;
    logic [4:0]         out_idx_reg;
    logic [2:0]         out_st_reg;
    logic               accept;
    logic               finish;
    logic               steal_v;
    logic [BW-1:0]      steal_bkt;
    hbc_pkg::pkt_t      inject;
    hbc_pkg::upd_t      upd;
    hbc_pkg::pkt_t      chain [NUM_BUFFERS+1];

    assign in_stall = (state_reg != hbc_pkg::S_IDLE);
    assign accept   = in_valid && !in_stall;
    assign finish   = (state_reg == hbc_pkg::S_DONE) && (!out_valid_reg || !out_stall);

    // reduce the block number modulo the bucket count: fold the bytes by
    // their weights, divide the small sum by reciprocal multiply, subtract
    assign fold_next = FOLD_W'(blk_reg[7:0]) +
                       FOLD_W'(blk_reg[15:8]) * FOLD_W'(C1) +
                       FOLD_W'(blk_reg[23:16]) * FOLD_W'(C2) +
                       FOLD_W'(blk_reg[31:24]) * FOLD_W'(C3);
    assign rec_prod  = 32'(fold_reg) * 32'(REC_M);
    assign quot_next = rec_prod[31:REC_S];
    assign rem_full  = fold_reg - quot_reg * FOLD_W'(NUM_BUCKETS);

    // first bucket after home, in circular order, that has a free buffer
    always_comb
    begin
        logic [BW:0] b;
        steal_v   = 1'b0;
        steal_bkt = '0;
        b         = '0;
        for (int off = NUM_BUCKETS - 1; off >= 1; off--)
        begin
            b = (BW+1)'(home_reg) + (BW+1)'(off);
            if (b >= (BW+1)'(NUM_BUCKETS))
            begin
                b = b - (BW+1)'(NUM_BUCKETS);
            end
            if (chain[NUM_BUFFERS].free_mask[b[BW-1:0]])
            begin
                steal_v   = 1'b1;
                steal_bkt = b[BW-1:0];
            end
        end
    end

    // sequence one word
    always_comb
    begin
        state_next    = state_reg;
        res_idx_next  = res_idx_reg;
        res_st_next   = res_st_reg;
        res_kind_next = res_kind_reg;
        res_upd_next  = res_upd_reg;
        inject        = '0;
        inject.dev    = dev_reg;
        inject.blk    = blk_reg;
        inject.bucket = home_reg;
        unique case (state_reg)
            hbc_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    if (opcode)
                    begin
                        res_idx_next  = IW'(release_index);
                        res_st_next   = hbc_pkg::ST_RELEASED;
                        res_kind_next = hbc_pkg::UPD_REL;
                        res_upd_next  = 1'b1;
                        state_next    = hbc_pkg::S_DONE;
                    end
                    else
                    begin
                        state_next = hbc_pkg::S_MOD;
                    end
                end
            end
            hbc_pkg::S_MOD:
            begin
                if (cnt_reg == 2'd2)
                begin
                    state_next = hbc_pkg::S_PASS1_GO;
                end
            end
            hbc_pkg::S_PASS1_GO:
            begin
                inject.valid = 1'b1;
                state_next   = hbc_pkg::S_PASS1_WAIT;
            end
            hbc_pkg::S_PASS1_WAIT:
            begin
                if (chain[NUM_BUFFERS].valid)
                begin
                    state_next = hbc_pkg::S_DONE;
                    if (chain[NUM_BUFFERS].match_v)
                    begin
                        res_idx_next  = chain[NUM_BUFFERS].match_idx;
                        res_st_next   = hbc_pkg::ST_HIT;
                        res_kind_next = hbc_pkg::UPD_INC;
                        res_upd_next  = 1'b1;
                    end
                    else if (chain[NUM_BUFFERS].free_v)
                    begin
                        res_idx_next  = chain[NUM_BUFFERS].free_idx;
                        res_st_next   = hbc_pkg::ST_REUSE;
                        res_kind_next = hbc_pkg::UPD_CLAIM;
                        res_upd_next  = 1'b1;
                    end
                    else if (steal_v)
                    begin
                        state_next = hbc_pkg::S_PASS2_GO;
                    end
                    else
                    begin
                        res_idx_next = '0;
                        res_st_next  = hbc_pkg::ST_NONE;
                        res_upd_next = 1'b0;
                    end
                end
            end
            hbc_pkg::S_PASS2_GO:
            begin
                inject.valid  = 1'b1;
                inject.bucket = target_reg;
                state_next    = hbc_pkg::S_PASS2_WAIT;
            end
            hbc_pkg::S_PASS2_WAIT:
            begin
                if (chain[NUM_BUFFERS].valid)
                begin
                    res_idx_next  = chain[NUM_BUFFERS].free_idx;
                    res_st_next   = hbc_pkg::ST_STEAL;
                    res_kind_next = hbc_pkg::UPD_CLAIM;
                    res_upd_next  = 1'b1;
                    state_next    = hbc_pkg::S_DONE;
                end
            end
            hbc_pkg::S_DONE:
            begin
                if (finish)
                begin
                    state_next = hbc_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = hbc_pkg::S_IDLE;
            end
        endcase
    end

    // broadcast the entry update as the result leaves
    always_comb
    begin
        upd       = '0;
        upd.valid = finish && res_upd_reg;
        upd.kind  = res_kind_reg;
        upd.idx   = res_idx_reg;
        upd.dev   = dev_reg;
        upd.blk   = blk_reg;
        upd.home  = home_reg;
        upd.tick  = tick_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= hbc_pkg::S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (finish)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // hold the word's fields and the search results
    always_ff @(posedge clk)
    begin
        res_idx_reg  <= res_idx_next;
        res_st_reg   <= res_st_next;
        res_kind_reg <= res_kind_next;
        res_upd_reg  <= res_upd_next;
        if (accept)
        begin
            op_reg    <= opcode;
            dev_reg   <= device_id;
            blk_reg   <= block_number;
            rel_reg   <= IW'(release_index);
            tick_reg  <= now_tick;
            cnt_reg   <= '0;
        end
        else if (state_reg == hbc_pkg::S_MOD)
        begin
            fold_reg  <= fold_next;
            quot_reg  <= quot_next;
            home_reg  <= rem_full[BW-1:0];
            cnt_reg   <= cnt_reg + 1'b1;
        end
        if (state_reg == hbc_pkg::S_PASS1_WAIT)
        begin
            target_reg <= steal_bkt;
        end
        if (finish)
        begin
            out_idx_reg <= res_idx_reg[4:0];
            out_st_reg  <= res_st_reg;
        end
    end

    // row of entry cells
    assign chain[0] = inject;

    for (genvar i = 0; i < NUM_BUFFERS; i++)
    begin : g_cell
        hbc_cell #(
            .IDX         (i),
            .NUM_BUCKETS (NUM_BUCKETS)
        ) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .pkt_in  (chain[i]),
            .upd     (upd),
            .pkt_out (chain[i+1])
        );
    end

    assign out_valid    = out_valid_reg;
    assign buffer_index = out_idx_reg;
    assign status       = out_st_reg;

    // search word leaves the row only while it is awaited
    a_tail_awaited: assert property (@(posedge clk) disable iff (!rst_n)
        chain[NUM_BUFFERS].valid |-> (state_reg == hbc_pkg::S_PASS1_WAIT ||
                                      state_reg == hbc_pkg::S_PASS2_WAIT))
        else $error("search word arrived outside a wait state");

    // a second pass always finds a free buffer
    a_pass2_found: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == hbc_pkg::S_PASS2_WAIT && chain[NUM_BUFFERS].valid) |->
        chain[NUM_BUFFERS].free_v)
        else $error("second pass found no free buffer");

    // an accepted word occupies the sequencer
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> in_stall)
        else $error("sequencer idle right after accepting a word");

    // a release goes straight to the result
    a_release_direct: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && opcode) |=> (state_reg == hbc_pkg::S_DONE && op_reg &&
                                rel_reg == res_idx_reg))
        else $error("release did not go straight to the result");

endmodule

`default_nettype wire
